// ===== hw/rtl/csb_pkg.sv =====
// Shared constants and codes for the clipped transparent sprite blit.
`default_nettype none
package csb_pkg;

  localparam int REG_DIM_BITS = 12;
  localparam int APB_ADDR_W   = 5;
  localparam int APB_DATA_W   = 32;
  localparam int POS_W        = 16;
  localparam int PIXEL_W      = 8;
  localparam int WADDR_W      = 24;
  localparam int TABLE_DEPTH  = 256;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_TABLE = 2'd2;

  localparam logic [1:0] MODE_COPY  = 2'd0;
  localparam logic [1:0] MODE_REMAP = 2'd1;
  localparam logic [1:0] MODE_FILL  = 2'd2;

  localparam logic [2:0] REG_SPRITE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SPRITE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SURFACE_PITCH  = 3'd4;
  localparam logic [2:0] REG_DRAW_MODE      = 3'd5;
  localparam logic [2:0] REG_FILL_COLOR     = 3'd6;

endpackage
`default_nettype wire

// ===== hw/rtl/csb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/clipped_transparent_sprite_blit.sv =====
// Top level of the clipped transparent sprite blit.
//
// Requests arrive on the in_valid/in_ready channel. A start request latches
// the sprite origin and clears the row and column counters; a table request
// writes one remap entry; a pixel request is counted in raster order and,
// when opaque and inside the surface, yields one write request on the
// out_valid/out_ready channel (write_address, write_value).
// Throughput is one request per cycle while in_ready is high. A pixel that
// writes passes the counters, clip compare and remap RAM read into the
// middle stage, then the row * pitch multiply-add into the output register.
// Requests that give no write leave the output untouched.
// When the receiver stalls, the output register holds and one more pixel
// waits in the middle stage; in_ready drops only while both are full.
// Reset (rst, synchronous) clears the registers, the counters, the origin
// and the remap entry valid bits, so every entry reads as zero until written.
// Registers sit on the APB port at byte address 4 * index; pready is high.
`default_nettype none
module clipped_transparent_sprite_blit
  import csb_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             kind,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic [PIXEL_W-1:0]     pixel,
  input  wire logic [PIXEL_W-1:0]     table_index,
  input  wire logic [PIXEL_W-1:0]     table_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [WADDR_W-1:0]     write_address,
  output logic      [PIXEL_W-1:0]     write_value
);

  localparam int DIM_W = (COORD_BITS < REG_DIM_BITS) ? COORD_BITS : REG_DIM_BITS;
  localparam int SUM_W = 2 * DIM_W + 1;
  localparam int TAB_W = $clog2(TABLE_DEPTH);

  logic [DIM_W-1:0] sprite_width;
  logic [DIM_W-1:0] sprite_height;
  logic [DIM_W-1:0] surface_width;
  logic [DIM_W-1:0] surface_height;
  logic [DIM_W-1:0] surface_pitch;
  logic [1:0]       draw_mode;
  logic [7:0]       fill_color;

  logic signed [POS_W-1:0] origin_col;
  logic signed [POS_W-1:0] origin_row;
  logic [DIM_W-1:0]        cur_col;
  logic [DIM_W-1:0]        cur_row;
  logic [TABLE_DEPTH-1:0]  entry_valid;

  logic                s1_valid;
  logic [DIM_W-1:0]    s1_col;
  logic [DIM_W-1:0]    s1_row;
  logic [PIXEL_W-1:0]  s1_pixel;
  logic                s1_entry_valid;
  logic [PIXEL_W-1:0]  remap_data;

  logic                cfg_write;
  logic                accept;
  logic                pixel_take;
  logic                s1_move;
  logic                counting;
  logic                col_wrap;
  logic signed [POS_W:0] col_abs;
  logic signed [POS_W:0] row_abs;
  logic                visible;
  logic [2*DIM_W-1:0]  row_offset;
  logic [SUM_W-1:0]    addr_sum;
  logic [PIXEL_W-1:0]  value_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width   <= '0;
      sprite_height  <= '0;
      surface_width  <= '0;
      surface_height <= '0;
      surface_pitch  <= '0;
      draw_mode      <= MODE_COPY;
      fill_color     <= '0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_SPRITE_WIDTH:   sprite_width   <= pwdata[DIM_W-1:0];
        REG_SPRITE_HEIGHT:  sprite_height  <= pwdata[DIM_W-1:0];
        REG_SURFACE_WIDTH:  surface_width  <= pwdata[DIM_W-1:0];
        REG_SURFACE_HEIGHT: surface_height <= pwdata[DIM_W-1:0];
        REG_SURFACE_PITCH:  surface_pitch  <= pwdata[DIM_W-1:0];
        REG_DRAW_MODE:      draw_mode      <= pwdata[1:0];
        REG_FILL_COLOR:     fill_color     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SPRITE_WIDTH:   prdata = APB_DATA_W'(sprite_width);
      REG_SPRITE_HEIGHT:  prdata = APB_DATA_W'(sprite_height);
      REG_SURFACE_WIDTH:  prdata = APB_DATA_W'(surface_width);
      REG_SURFACE_HEIGHT: prdata = APB_DATA_W'(surface_height);
      REG_SURFACE_PITCH:  prdata = APB_DATA_W'(surface_pitch);
      REG_DRAW_MODE:      prdata = APB_DATA_W'(draw_mode);
      REG_FILL_COLOR:     prdata = APB_DATA_W'(fill_color);
      default:            prdata = '0;
    endcase
  end

  assign s1_move  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;

  assign counting = (sprite_width != '0) && (cur_row < sprite_height);
  assign pixel_take = accept && (kind == KIND_PIXEL) && counting;
  assign col_wrap = ({1'b0, cur_col} + 1'b1) >= {1'b0, sprite_width};

  assign col_abs = {origin_col[POS_W-1], origin_col} + $signed({1'b0, POS_W'(cur_col)});
  assign row_abs = {origin_row[POS_W-1], origin_row} + $signed({1'b0, POS_W'(cur_row)});
  assign visible = (pixel != '0)
                && !col_abs[POS_W] && (col_abs[POS_W-1:0] < POS_W'(surface_width))
                && !row_abs[POS_W] && (row_abs[POS_W-1:0] < POS_W'(surface_height));

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_col  <= '0;
      origin_row  <= '0;
      cur_col     <= '0;
      cur_row     <= '0;
      entry_valid <= '0;
    end else if (accept) begin
      case (kind)
        KIND_START: begin
          origin_col <= pos_x;
          origin_row <= pos_y;
          cur_col    <= '0;
          cur_row    <= '0;
        end
        KIND_TABLE: begin
          entry_valid[table_index] <= 1'b1;
        end
        KIND_PIXEL: begin
          if (counting) begin
            if (col_wrap) begin
              cur_col <= '0;
              cur_row <= cur_row + 1'b1;
            end else begin
              cur_col <= cur_col + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  csb_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_remap (
    .clk   (clk),
    .we    (accept && (kind == KIND_TABLE)),
    .waddr (table_index[TAB_W-1:0]),
    .wdata (table_value),
    .re    (pixel_take),
    .raddr (pixel[TAB_W-1:0]),
    .rdata (remap_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= pixel_take && visible;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      s1_col         <= col_abs[DIM_W-1:0];
      s1_row         <= row_abs[DIM_W-1:0];
      s1_pixel       <= pixel;
      s1_entry_valid <= entry_valid[pixel];
    end
  end

  assign row_offset = (2 * DIM_W)'(s1_row) * (2 * DIM_W)'(surface_pitch);
  assign addr_sum   = SUM_W'(row_offset) + SUM_W'(s1_col);

  always_comb begin
    case (draw_mode)
      MODE_REMAP: value_sel = s1_entry_valid ? remap_data : '0;
      MODE_FILL:  value_sel = fill_color;
      default:    value_sel = s1_pixel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      write_address <= WADDR_W'(addr_sum);
      write_value   <= value_sel;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/csb_checker.sv =====
// Port-level checks for the clipped transparent sprite blit, bound to the top.
`default_nettype none
module csb_checker
  import csb_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         kind,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [WADDR_W-1:0] write_address,
  input wire logic [PIXEL_W-1:0] write_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_address) && $stable(write_value))
    else $error("stalled write request changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("write request present right after reset");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without an output stall");

  a_write_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (kind == KIND_PIXEL), 2))
    else $error("write request without a pixel two cycles earlier");

endmodule

bind clipped_transparent_sprite_blit csb_checker u_csb_checker (.*);
`default_nettype wire
